// ----- src/planar_pose_arithmetic_defines.svh -----
// Assertion macros shared by the pose arithmetic RTL.
`ifndef PLANAR_POSE_ARITHMETIC_DEFINES_SVH
`define PLANAR_POSE_ARITHMETIC_DEFINES_SVH

// Implication checked in the same cycle, ignored while reset is held.
`define PPA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequence is checked in the next cycle, also across reset.
`define PPA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/ppa_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package ppa_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int ATAN_LEN      = 24;
    localparam int NROT          = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;
    localparam int VW            = 42;   // rotator vector width, 8 guard bits
    localparam int ZW            = 34;   // rotator angle width
    localparam int NSTG          = NROT + 5;
    localparam logic signed [32:0] GAIN_INV = 33'sd2608131496;

    typedef enum logic [2:0] {
        CMD_ADD    = 3'd0,
        CMD_SUB    = 3'd1,
        CMD_TRANS  = 3'd2,
        CMD_ROT    = 3'd3,
        CMD_COMP   = 3'd4,
        CMD_INTERP = 3'd5
    } t_cmd;

    typedef struct packed {
        logic [2:0]          cmd;
        logic signed [31:0]  ax, ay;
        logic signed [15:0]  ah;
        logic signed [31:0]  ac, bx, by;
        logic signed [15:0]  bh;
        logic signed [31:0]  bc;
        logic [16:0]         f;
    } t_in;

    typedef struct packed {
        logic [2:0]          cmd;
        logic signed [31:0]  px, py;
        logic signed [15:0]  ang;
        logic signed [31:0]  offx, offy;
        logic signed [15:0]  h;
        logic signed [32:0]  sx, sy;
        logic signed [31:0]  ax, ay, ac;
        logic signed [15:0]  ah;
        logic signed [32:0]  dx, dy, dc;
        logic signed [16:0]  dh;
        logic [16:0]         f;
    } t_sa;

    typedef struct packed {
        logic [2:0]          cmd;
        logic signed [64:0]  prx, pry;
        logic signed [15:0]  ang;
        logic signed [31:0]  offx, offy;
        logic signed [15:0]  h;
        logic signed [32:0]  sx, sy;
        logic signed [31:0]  ax, ay, ac;
        logic signed [15:0]  ah;
        logic signed [50:0]  mx, my, mc;
        logic signed [34:0]  mh;
    } t_sb;

    typedef struct packed {
        logic [2:0]          cmd;
        logic signed [31:0]  offx, offy;
        logic signed [15:0]  h;
        logic signed [32:0]  sx, sy;
        logic signed [31:0]  c;
    } t_side;

    typedef struct packed {
        logic [2:0]          cmd;
        logic signed [31:0]  x, y;
        logic signed [15:0]  h;
        logic signed [31:0]  c;
        logic                sat;
    } t_out;

    function automatic logic [31:0] atan_entry(input logic [4:0] i);
        logic [31:0] v;
        unique case (i)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051D;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2E;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2F9;
            5'd15: v = 32'h0000517C;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A2F;
            5'd19: v = 32'h00000517;
            5'd20: v = 32'h0000028B;
            5'd21: v = 32'h00000145;
            5'd22: v = 32'h000000A2;
            5'd23: v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

    // Clamp to 32 bits; the top bit of the result is the clamp flag.
    function automatic logic [32:0] sat35(input logic signed [34:0] v);
        logic [32:0] r;
        if (v > 35'sd2147483647) begin
            r = {1'b1, 32'h7FFFFFFF};
        end else if (v < -35'sd2147483648) begin
            r = {1'b1, 32'h80000000};
        end else begin
            r = {1'b0, v[31:0]};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- src/planar_pose_arithmetic.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Planar pose arithmetic: add, subtract, translate, rotate, compose or interpolate two
// planar poses (Q16.16 position, 16-bit binary heading, Q16.16 curvature).
// The slave channel takes one pose pair per transaction, the command in s_axis_tuser.
// The master channel returns one result pose and a clamp flag per transaction.
// The datapath is a chain of CORDIC_STAGES + 5 register stages: input register,
// operand selection, multipliers, rounding and quadrant fold, one CORDIC
// micro-rotation per stage, and a final round, offset add and saturation stage.
// One transaction can be accepted in every clock cycle while the receiver is not
// stalling; the single-cycle rate is set by the fully pipelined rotator.
// Each stage holds a valid bit and advances when it is empty or the stage after it
// advances, so when the receiver stalls, bubbles are squeezed out first and the
// slave side only deasserts tready once every stage holds a transaction.
// Synchronous reset (i_rst_n low) clears all valid bits; the datapath keeps its data.
module planar_pose_arithmetic (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // a_x, a_y, a_heading, a_curvature, b_x, b_y, b_heading, b_curvature, frac, zero pad
    input  wire logic [247:0] s_axis_tdata,
    // cmd
    input  wire logic [2:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // out_x, out_y, out_heading, out_curvature, saturated, zero pad
    output logic [119:0]      m_axis_tdata
);

`include "planar_pose_arithmetic_defines.svh"

    localparam int N = ppa_pkg::NROT;
    localparam int S = ppa_pkg::NSTG;

    logic [S-1:0] r_v;
    logic [S:0]   w_en;

    ppa_pkg::t_in   r_in, n_in;
    ppa_pkg::t_sa   r_sa, n_sa;
    ppa_pkg::t_sb   r_sb, n_sb;
    ppa_pkg::t_out  r_out, n_out;

    // Rotator registers: index 0 is the fold stage, index i+1 follows micro-rotation i.
    logic signed [ppa_pkg::VW-1:0] r_cx [0:N];
    logic signed [ppa_pkg::VW-1:0] r_cy [0:N];
    logic signed [ppa_pkg::ZW-1:0] r_cz [0:N];
    ppa_pkg::t_side                r_side [0:N];

    logic signed [ppa_pkg::VW-1:0] n_cx0, n_cy0;
    logic signed [ppa_pkg::ZW-1:0] n_cz0;
    ppa_pkg::t_side                n_side0;

    // A stage advances when it is empty or its successor advances.
    always_comb begin
        w_en[S] = m_axis_tready;
        for (int k = S - 1; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign s_axis_tready = w_en[0];
    assign m_axis_tvalid = r_v[S-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < S; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // Input register.
    always_comb begin
        n_in.cmd = s_axis_tuser;
        n_in.ax  = s_axis_tdata[31:0];
        n_in.ay  = s_axis_tdata[63:32];
        n_in.ah  = s_axis_tdata[79:64];
        n_in.ac  = s_axis_tdata[111:80];
        n_in.bx  = s_axis_tdata[143:112];
        n_in.by  = s_axis_tdata[175:144];
        n_in.bh  = s_axis_tdata[191:176];
        n_in.bc  = s_axis_tdata[223:192];
        n_in.f   = s_axis_tdata[240:224];
    end

    // Operand selection, simple sums and interpolation differences.
    always_comb begin
        n_sa.cmd  = r_in.cmd;
        n_sa.ax   = r_in.ax;
        n_sa.ay   = r_in.ay;
        n_sa.ac   = r_in.ac;
        n_sa.ah   = r_in.ah;
        n_sa.dx   = 33'(r_in.bx) - 33'(r_in.ax);
        n_sa.dy   = 33'(r_in.by) - 33'(r_in.ay);
        n_sa.dc   = 33'(r_in.bc) - 33'(r_in.ac);
        n_sa.dh   = 17'(r_in.bh) - 17'(r_in.ah);
        // A fraction above one is clamped to one.
        n_sa.f    = (r_in.f[16] && (|r_in.f[15:0])) ? 17'h10000 : r_in.f;
        n_sa.px   = r_in.ax;
        n_sa.py   = r_in.ay;
        n_sa.ang  = r_in.bh;
        n_sa.offx = '0;
        n_sa.offy = '0;
        n_sa.h    = r_in.ah;
        n_sa.sx   = 33'(r_in.ax);
        n_sa.sy   = 33'(r_in.ay);
        unique case (r_in.cmd)
            ppa_pkg::CMD_ADD: begin
                n_sa.sx = 33'(r_in.ax) + 33'(r_in.bx);
                n_sa.sy = 33'(r_in.ay) + 33'(r_in.by);
                n_sa.h  = r_in.ah + r_in.bh;
            end
            ppa_pkg::CMD_SUB: begin
                n_sa.sx = 33'(r_in.ax) - 33'(r_in.bx);
                n_sa.sy = 33'(r_in.ay) - 33'(r_in.by);
                n_sa.h  = r_in.ah - r_in.bh;
            end
            ppa_pkg::CMD_TRANS: begin
                n_sa.sx = 33'(r_in.ax) + 33'(r_in.bx);
                n_sa.sy = 33'(r_in.ay) + 33'(r_in.by);
            end
            ppa_pkg::CMD_ROT: begin
                n_sa.h = r_in.ah + r_in.bh;
            end
            ppa_pkg::CMD_COMP: begin
                // Rotate b's position by a's heading, then add a's position.
                n_sa.px   = r_in.bx;
                n_sa.py   = r_in.by;
                n_sa.ang  = r_in.ah;
                n_sa.offx = r_in.ax;
                n_sa.offy = r_in.ay;
                n_sa.h    = r_in.ah + r_in.bh;
            end
            default: begin
            end
        endcase
    end

    // Multipliers: gain prescale for the rotator and the interpolation products.
    always_comb begin
        n_sb.cmd  = r_sa.cmd;
        n_sb.prx  = 65'(r_sa.px) * 65'(ppa_pkg::GAIN_INV);
        n_sb.pry  = 65'(r_sa.py) * 65'(ppa_pkg::GAIN_INV);
        n_sb.ang  = r_sa.ang;
        n_sb.offx = r_sa.offx;
        n_sb.offy = r_sa.offy;
        n_sb.h    = r_sa.h;
        n_sb.sx   = r_sa.sx;
        n_sb.sy   = r_sa.sy;
        n_sb.ax   = r_sa.ax;
        n_sb.ay   = r_sa.ay;
        n_sb.ac   = r_sa.ac;
        n_sb.ah   = r_sa.ah;
        n_sb.mx   = 51'(r_sa.dx) * 51'(signed'({1'b0, r_sa.f}));
        n_sb.my   = 51'(r_sa.dy) * 51'(signed'({1'b0, r_sa.f}));
        n_sb.mc   = 51'(r_sa.dc) * 51'(signed'({1'b0, r_sa.f}));
        n_sb.mh   = 35'(r_sa.dh) * 35'(signed'({1'b0, r_sa.f}));
    end

    // Rounding of the prescale and interpolation, quadrant fold for the rotator.
    always_comb begin
        logic signed [64:0] tx, ty;
        logic signed [50:0] lx, ly, lc;
        logic signed [34:0] lh;
        logic signed [ppa_pkg::VW-1:0] vx, vy;
        logic signed [ppa_pkg::ZW-1:0] z;
        tx = r_sb.prx + 65'sd2147483648;
        ty = r_sb.pry + 65'sd2147483648;
        vx = {{(ppa_pkg::VW-40){tx[63]}}, tx[63:32], 8'h00};
        vy = {{(ppa_pkg::VW-40){ty[63]}}, ty[63:32], 8'h00};
        z  = {{(ppa_pkg::ZW-32){r_sb.ang[15]}}, r_sb.ang, 16'h0000};
        if (r_sb.ang > 16'sd16384) begin
            vx = -vx;
            vy = -vy;
            z  = z - (ppa_pkg::ZW)'(34'sd2147483648);
        end else if (r_sb.ang < -16'sd16384) begin
            vx = -vx;
            vy = -vy;
            z  = z + (ppa_pkg::ZW)'(34'sd2147483648);
        end
        n_cx0 = vx;
        n_cy0 = vy;
        n_cz0 = z;

        lx = r_sb.mx + 51'sd32768;
        ly = r_sb.my + 51'sd32768;
        lc = r_sb.mc + 51'sd32768;
        lh = r_sb.mh + 35'sd32768;
        n_side0.cmd  = r_sb.cmd;
        n_side0.offx = r_sb.offx;
        n_side0.offy = r_sb.offy;
        n_side0.h    = r_sb.h;
        n_side0.sx   = r_sb.sx;
        n_side0.sy   = r_sb.sy;
        n_side0.c    = r_sb.ac;
        if (r_sb.cmd == ppa_pkg::CMD_INTERP) begin
            n_side0.sx = 33'(r_sb.ax) + lx[48:16];
            n_side0.sy = 33'(r_sb.ay) + ly[48:16];
            n_side0.c  = r_sb.ac + lc[47:16];
            n_side0.h  = r_sb.ah + lh[31:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_in <= n_in;
        end
        if (w_en[1]) begin
            r_sa <= n_sa;
        end
        if (w_en[2]) begin
            r_sb <= n_sb;
        end
        if (w_en[3]) begin
            r_cx[0]   <= n_cx0;
            r_cy[0]   <= n_cy0;
            r_cz[0]   <= n_cz0;
            r_side[0] <= n_side0;
        end
    end

    // One CORDIC micro-rotation per stage.
    for (genvar g = 0; g < N; g++) begin : g_rot
        logic signed [ppa_pkg::VW-1:0] n_x, n_y;
        logic signed [ppa_pkg::ZW-1:0] n_z, w_at;

        assign w_at = (ppa_pkg::ZW)'(ppa_pkg::atan_entry(5'(g)));

        always_comb begin
            if (!r_cz[g][ppa_pkg::ZW-1]) begin
                n_x = r_cx[g] - (r_cy[g] >>> g);
                n_y = r_cy[g] + (r_cx[g] >>> g);
                n_z = r_cz[g] - w_at;
            end else begin
                n_x = r_cx[g] + (r_cy[g] >>> g);
                n_y = r_cy[g] - (r_cx[g] >>> g);
                n_z = r_cz[g] + w_at;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en[g+4]) begin
                r_cx[g+1]   <= n_x;
                r_cy[g+1]   <= n_y;
                r_cz[g+1]   <= n_z;
                r_side[g+1] <= r_side[g];
            end
        end
    end

    // Remove guard bits, add offset, saturate and pick the result.
    always_comb begin
        logic signed [ppa_pkg::VW-1:0] tx, ty;
        logic signed [34:0] fx, fy;
        logic [32:0] qx, qy;
        tx = r_cx[N] + (ppa_pkg::VW)'(128);
        ty = r_cy[N] + (ppa_pkg::VW)'(128);
        fx = 35'(r_side[N].sx);
        fy = 35'(r_side[N].sy);
        if (r_side[N].cmd == ppa_pkg::CMD_ROT || r_side[N].cmd == ppa_pkg::CMD_COMP) begin
            fx = 35'($signed(tx[ppa_pkg::VW-1:8])) + 35'(r_side[N].offx);
            fy = 35'($signed(ty[ppa_pkg::VW-1:8])) + 35'(r_side[N].offy);
        end
        qx = ppa_pkg::sat35(fx);
        qy = ppa_pkg::sat35(fy);
        n_out.cmd = r_side[N].cmd;
        n_out.x   = qx[31:0];
        n_out.y   = qy[31:0];
        n_out.h   = r_side[N].h;
        n_out.c   = r_side[N].c;
        n_out.sat = qx[32] | qy[32];
    end

    always_ff @(posedge i_clk) begin
        if (w_en[S-1]) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tdata = {7'b0, r_out.sat, r_out.c, r_out.h, r_out.y, r_out.x};

    `PPA_ASSERT_IMP(a_interp_never_clamps, m_axis_tvalid && r_out.cmd == ppa_pkg::CMD_INTERP, !r_out.sat, "interpolation result was clamped")
    `PPA_ASSERT_NXT(a_reset_empties, !i_rst_n, !m_axis_tvalid && s_axis_tready, "pipeline not empty after reset")
    `PPA_ASSERT_IMP(a_full_stall_blocks, (&r_v) && !m_axis_tready, !s_axis_tready, "accepted into a full stalled pipeline")
    `PPA_ASSERT_IMP(a_free_entry_ready, !r_v[0], s_axis_tready, "input stage empty but not ready")

endmodule
`default_nettype wire

// ----- tb/sv/planar_pose_arithmetic_checker.sv -----
`timescale 1ns / 1ps
// Watches both stream channels, predicts each result pose and compares.
module planar_pose_arithmetic_checker (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    input  wire logic         i_in_ready,
    input  wire logic [247:0] i_in_data,
    input  wire logic [2:0]   i_in_cmd,
    input  wire logic         i_out_valid,
    input  wire logic         i_out_ready,
    input  wire logic [119:0] i_out_data,
    output int                o_fail_count,
    output int                o_pending,
    output logic              o_accepted
);

    // Packed with x in the lowest bits, as on the master channel.
    typedef struct packed {
        logic        sat;
        logic [31:0] c;
        logic [15:0] h;
        logic [31:0] y;
        logic [31:0] x;
    } t_pose_res;

    t_pose_res expected_poses[$];
    int fails;

    assign o_fail_count = fails;
    assign o_pending    = expected_poses.size();
    assign o_accepted   = (i_in_valid && i_in_ready) || (i_out_valid && i_out_ready);

    function automatic longint floor_div(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint atan_val(input int i);
        longint t[24] = '{
            64'h20000000, 64'h12E4051D, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
            64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2E,
            64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2F9,
            64'h0000517C, 64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
            64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051};
        return t[i];
    endfunction

    // Fixed-point CORDIC rotation with gain prescale and quadrant fold.
    task automatic cordic_rotate(input longint px, input longint py, input longint ang,
                                 output longint rx, output longint ry);
        longint z, x, y, dx, dy;
        z = ang * 65536;
        x = floor_div(px * 64'sd2608131496 + (64'sd1 << 31), 32) * 256;
        y = floor_div(py * 64'sd2608131496 + (64'sd1 << 31), 32) * 256;
        if (z > (64'sd1 << 30)) begin
            x = -x; y = -y; z -= (64'sd1 << 31);
        end else if (z < -(64'sd1 << 30)) begin
            x = -x; y = -y; z += (64'sd1 << 31);
        end
        for (int i = 0; i < ppa_pkg::NROT; i++) begin
            dx = floor_div(y, i);
            dy = floor_div(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_val(i);
            end else begin
                x += dx; y -= dy; z += atan_val(i);
            end
        end
        rx = floor_div(x + 128, 8);
        ry = floor_div(y + 128, 8);
    endtask

    function automatic longint clamp32(input longint v, inout logic flag);
        if (v > 64'sd2147483647) begin
            flag = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            flag = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint blend(input longint a, input longint b, input longint f);
        return a + floor_div((b - a) * f + 32768, 16);
    endfunction

    task automatic predict_pose(input logic [247:0] d, input logic [2:0] cmd);
        longint ax, ay, ah, ac, bx, by, bh, bc, f, x, y, h, c, rx, ry;
        logic flag;
        t_pose_res r;
        ax = longint'($signed(d[31:0]));
        ay = longint'($signed(d[63:32]));
        ah = longint'($signed(d[79:64]));
        ac = longint'($signed(d[111:80]));
        bx = longint'($signed(d[143:112]));
        by = longint'($signed(d[175:144]));
        bh = longint'($signed(d[191:176]));
        bc = longint'($signed(d[223:192]));
        f  = longint'(d[240:224]);
        if (f > 65536) f = 65536;
        x = ax; y = ay; h = ah; c = ac; flag = 1'b0;
        case (cmd)
            ppa_pkg::CMD_ADD: begin
                x = ax + bx; y = ay + by; h = ah + bh;
            end
            ppa_pkg::CMD_SUB: begin
                x = ax - bx; y = ay - by; h = ah - bh;
            end
            ppa_pkg::CMD_TRANS: begin
                x = ax + bx; y = ay + by;
            end
            ppa_pkg::CMD_ROT: begin
                cordic_rotate(ax, ay, bh, rx, ry);
                x = rx; y = ry; h = ah + bh;
            end
            ppa_pkg::CMD_COMP: begin
                cordic_rotate(bx, by, ah, rx, ry);
                x = rx + ax; y = ry + ay; h = ah + bh;
            end
            ppa_pkg::CMD_INTERP: begin
                x = blend(ax, bx, f);
                y = blend(ay, by, f);
                c = blend(ac, bc, f);
                h = blend(ah, bh, f);
            end
            default: ;
        endcase
        x = clamp32(x, flag);
        y = clamp32(y, flag);
        c = clamp32(c, flag);
        r.x = x[31:0]; r.y = y[31:0]; r.h = h[15:0]; r.c = c[31:0]; r.sat = flag;
        expected_poses.push_back(r);
    endtask

    always @(posedge i_clk) begin
        t_pose_res e, g;
        if (!i_rst_n) begin
            fails <= 0;
        end else begin
            if (i_in_valid && i_in_ready) predict_pose(i_in_data, i_in_cmd);
            if (i_out_valid && i_out_ready) begin
                g = i_out_data[112:0];
                if (expected_poses.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, g);
                    fails <= fails + 1;
                end else begin
                    e = expected_poses.pop_front();
                    if (e.x !== g.x || e.y !== g.y || e.h !== g.h || e.c !== g.c
                            || e.sat !== g.sat) begin
                        $display("%0t: mismatch x/y/h/c/sat expected %h %h %h %h %b",
                                 $time, e.x, e.y, e.h, e.c, e.sat);
                        $display("%0t:                     actual   %h %h %h %h %b",
                                 $time, g.x, g.y, g.h, g.c, g.sat);
                        fails <= fails + 1;
                    end
                end
            end
        end
    end

endmodule

// ----- tb/sv/planar_pose_arithmetic_tb.sv -----
`timescale 1ns / 1ps
// Top of the pose arithmetic testbench. It drives pose pairs into the slave
// channel, stalls the master channel and gives the verdict; the checker does
// the prediction and the comparison of every transaction.
module planar_pose_arithmetic_tb;

    localparam int PIPE_DEPTH  = ppa_pkg::CORDIC_STAGES + 4;
    localparam int IDLE_LIMIT  = 5000;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [247:0] s_axis_tdata = '0;   // a_x, a_y, a_heading, a_curvature, b_x, b_y,
                                       // b_heading, b_curvature, frac, zero pad
    logic [2:0]   s_axis_tuser = '0;   // cmd
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [119:0] m_axis_tdata;        // out_x, out_y, out_heading, out_curvature,
                                       // saturated, zero pad
    int           fail_count;
    int           pending;
    logic         accepted;

    // Idle percentages for each side; the phase changes these as the run moves on.
    int  send_idle_pct = 26;
    int  recv_idle_pct = 52;
    bit  recv_hold     = 1'b0;
    int  idle_cycles   = 0;

    always #5 i_clk = ~i_clk;

    planar_pose_arithmetic dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    planar_pose_arithmetic_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_in_cmd     (s_axis_tuser),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_accepted   (accepted)
    );

    // The receiver decides its ready at each falling edge, so that the rising
    // edge always sees a settled value. A long hold lets the pipeline fill up.
    always @(negedge i_clk) begin
        if (recv_hold) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: a long run of cycles with no transaction on either side ends the run.
    always @(posedge i_clk) begin
        if (!i_rst_n || accepted) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("FAIL planar_pose_arithmetic");
                $finish;
            end
        end
    end

    function automatic logic [31:0] rand_word();
        // Mostly full-range words, with the extremes and small values mixed in.
        case ($urandom_range(7))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return 32'($signed($urandom_range(200000)) - 100000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [16:0] rand_frac();
        case ($urandom_range(5))
            0: return 17'd0;
            1: return 17'd65536;
            2: return 17'($urandom_range(131071));
            default: return 17'($urandom_range(65536));
        endcase
    endfunction

    // Offers one transaction at the falling edge and holds it until accepted.
    task automatic send_pose(input logic [2:0] cmd, input logic [31:0] ax, input logic [31:0] ay,
                             input logic [15:0] ah, input logic [31:0] ac,
                             input logic [31:0] bx, input logic [31:0] by,
                             input logic [15:0] bh, input logic [31:0] bc,
                             input logic [16:0] f);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {7'b0, f, bc, bh, by, bx, ac, ah, ay, ax};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_random(input int count);
        logic [2:0] cmd;
        for (int n = 0; n < count; n++) begin
            // Mostly legal commands, now and then an unused code.
            cmd = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
            send_pose(cmd, rand_word(), rand_word(), 16'($urandom), rand_word(),
                      rand_word(), rand_word(), 16'($urandom), rand_word(), rand_frac());
        end
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part: each command, the field extremes, the turn past a
        // right angle, fractions of zero, one and above one, and unused codes.
        send_pose(ppa_pkg::CMD_ADD, 32'h7FFFFFFF, 32'h80000000, 16'h7FFF, 32'h7FFFFFFF,
                  32'h00000001, 32'hFFFFFFFF, 16'h0001, 32'h0, 17'd0);
        send_pose(ppa_pkg::CMD_SUB, 32'h80000000, 32'h7FFFFFFF, 16'h8000, 32'h80000000,
                  32'h00000001, 32'hFFFFFFFF, 16'h0001, 32'h0, 17'd0);
        send_pose(ppa_pkg::CMD_TRANS, 32'h00010000, 32'h00020000, 16'h1234, 32'h5,
                  32'h7FFFFFFF, 32'h7FFFFFFF, 16'h4000, 32'h0, 17'd0);
        send_pose(ppa_pkg::CMD_ROT, 32'h00010000, 32'h0, 16'h0, 32'h0, 32'h0, 32'h0,
                  16'h4000, 32'h0, 17'd0);
        send_pose(ppa_pkg::CMD_ROT, 32'h00010000, 32'h00010000, 16'h0, 32'h0, 32'h0, 32'h0,
                  16'h8000, 32'h0, 17'd0);
        send_pose(ppa_pkg::CMD_ROT, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'h0, 32'h0, 32'h0, 32'h0,
                  16'h2000, 32'h0, 17'd0);
        send_pose(ppa_pkg::CMD_ROT, 32'h80000000, 32'h80000000, 16'h0, 32'h0, 32'h0, 32'h0,
                  16'hC001, 32'h0, 17'd0);
        send_pose(ppa_pkg::CMD_COMP, 32'h7FFFFFFF, 32'h80000000, 16'h4001, 32'h0,
                  32'h7FFFFFFF, 32'h80000000, 16'h7FFF, 32'h0, 17'd0);
        send_pose(ppa_pkg::CMD_COMP, 32'h0, 32'h0, 16'hBFFF, 32'h0, 32'h00030000, 32'h0,
                  16'h0, 32'h0, 17'd0);
        send_pose(ppa_pkg::CMD_INTERP, 32'h80000000, 32'h7FFFFFFF, 16'h8000, 32'h80000000,
                  32'h7FFFFFFF, 32'h80000000, 16'h7FFF, 32'h7FFFFFFF, 17'd0);
        send_pose(ppa_pkg::CMD_INTERP, 32'h80000000, 32'h7FFFFFFF, 16'h8000, 32'h80000000,
                  32'h7FFFFFFF, 32'h80000000, 16'h7FFF, 32'h7FFFFFFF, 17'd65536);
        send_pose(ppa_pkg::CMD_INTERP, 32'h80000000, 32'h7FFFFFFF, 16'h8000, 32'h80000000,
                  32'h7FFFFFFF, 32'h80000000, 16'h7FFF, 32'h7FFFFFFF, 17'h1FFFF);
        send_pose(ppa_pkg::CMD_INTERP, 32'h0, 32'h0, 16'h7000, 32'h0, 32'h1, 32'hFFFFFFFF,
                  16'h9000, 32'h3, 17'd32768);
        send_pose(3'd6, 32'h12345678, 32'h9ABCDEF0, 16'h5555, 32'hAAAAAAAA,
                  32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 32'hFFFFFFFF, 17'h1FFFF);
        send_pose(3'd7, 32'hEDCBA987, 32'h65432100, 16'hAAAA, 32'h55555555,
                  32'h7FFFFFFF, 32'h7FFFFFFF, 16'h7FFF, 32'h7FFFFFFF, 17'd1);

        // The sender pauses here until every result has come back.
        drain();

        // Long receiver hold while the sender keeps offering: the pipeline
        // fills and the slave side must stall.
        fork
            begin
                recv_hold = 1'b1;
                repeat (3 * PIPE_DEPTH) @(posedge i_clk);
                recv_hold = 1'b0;
            end
            send_random(60);
        join

        send_random(420);
        send_idle_pct = 52;
        recv_idle_pct = 26;
        send_random(420);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random(420);

        drain();
        repeat (PIPE_DEPTH + 10) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("PASS planar_pose_arithmetic");
        end else begin
            $display("FAIL planar_pose_arithmetic");
        end
        $finish;
    end

endmodule
